FILE: rtl/pdts_pkg.sv
// shared constants, codes and control structs of the periodic task due scheduler
// no dependencies; imported by every module under rtl
package pdts_pkg;

  // time words and the serial digit that walks them
  localparam int TIME_W      = 32;
  localparam int DIGIT_W     = 8;
  localparam int NUM_DIG     = TIME_W / DIGIT_W;
  localparam int DIG_CNT_W   = (NUM_DIG > 1) ? $clog2(NUM_DIG) : 1;

  // table size default and register reset values
  localparam int MAX_TASKS_DEFAULT = 8;
  localparam logic [TIME_W-1:0] MIN_SLEEP_RESET = TIME_W'(8);

  // field widths of the stream words
  localparam int OPCODE_W   = 2;
  localparam int SLOT_IN_W  = 8;
  localparam int STATUS_W   = 2;
  localparam int ASSIGNED_W = 3;
  localparam int DUE_W      = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;

  // input word layout, lowest bit first
  localparam int IN_CUR_LSB  = 0;
  localparam int IN_PER_LSB  = IN_CUR_LSB + TIME_W;
  localparam int IN_RUN_LSB  = IN_PER_LSB + TIME_W;
  localparam int IN_SLOT_LSB = IN_RUN_LSB + 1;
  localparam int IN_GNT_LSB  = IN_SLOT_LSB + SLOT_IN_W;
  localparam int IN_USED_W   = IN_GNT_LSB + TIME_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

  // result word layout, lowest bit first
  localparam int OUT_USED_W = ASSIGNED_W + DUE_W + TIME_W + 1 + TIME_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // operation codes
  localparam logic [OPCODE_W-1:0] OP_ADD        = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_SET_PERIOD = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_POLL       = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_SLOT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLEEP_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLEEP  = 2'd1;

  // serial datapath commands
  localparam int CMD_W = 4;
  localparam logic [CMD_W-1:0] CMD_IDLE      = 4'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_NOW  = 4'd1;
  localparam logic [CMD_W-1:0] CMD_STEP_NOW  = 4'd2;
  localparam logic [CMD_W-1:0] CMD_LOAD_CHAN = 4'd3;
  localparam logic [CMD_W-1:0] CMD_STEP_CHAN = 4'd4;
  localparam logic [CMD_W-1:0] CMD_END_CHAN  = 4'd5;
  localparam logic [CMD_W-1:0] CMD_LOAD_FIN  = 4'd6;
  localparam logic [CMD_W-1:0] CMD_STEP_FIN  = 4'd7;
  localparam logic [CMD_W-1:0] CMD_END_FIN   = 4'd8;

  // sequencer to datapath
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             sleep_ok;  // sleep enabled and some channel ran
  } dp_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic chan_due;    // valid during the channel end step
    logic sleep_take;  // valid during the final end step
  } dp_stat_t;

  // channel table write strobes
  typedef struct packed {
    logic we_period;
    logic we_last;
  } tbl_wr_t;

endpackage

FILE: rtl/pdts_chan_table.sv
// channel table: period and last-run time of every channel
// depends on pdts_pkg; written by the sequencer, read one channel at a time
module pdts_chan_table import pdts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT,
  parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
  input  logic              clk,
  input  tbl_wr_t           wr,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [TIME_W-1:0] wr_period,
  input  logic [TIME_W-1:0] wr_last,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [TIME_W-1:0] rd_period,
  output logic [TIME_W-1:0] rd_last
);

  logic [TIME_W-1:0] period_mem [MAX_TASKS];
  logic [TIME_W-1:0] last_mem   [MAX_TASKS];
  logic [TIME_W-1:0] rd_period_r;
  logic [TIME_W-1:0] rd_last_r;

  // entries hold nothing meaningful until an add or set period writes them
  always_ff @(posedge clk) begin
    if (wr.we_period) begin
      period_mem[wr_idx] <= wr_period;
    end
    if (wr.we_last) begin
      last_mem[wr_idx] <= wr_last;
    end
  end

  // registered read port, addressed in the cycle before use
  always_ff @(posedge clk) begin
    rd_period_r <= period_mem[rd_idx];
    rd_last_r   <= last_mem[rd_idx];
  end

  assign rd_period = rd_period_r;
  assign rd_last   = rd_last_r;

endmodule

FILE: rtl/pdts_serial_path.sv
// digit-serial time datapath: adjusted time, due test, minimum and sleep offset
// depends on pdts_pkg; all words rotate one digit per cycle, lowest digit first
module pdts_serial_path import pdts_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctl_t           ctl,
  input  logic [TIME_W-1:0] cur_ms,
  input  logic [TIME_W-1:0] period_in,
  input  logic [TIME_W-1:0] granted,
  input  logic [TIME_W-1:0] min_sleep,
  input  logic [TIME_W-1:0] chan_period,
  input  logic [TIME_W-1:0] chan_last,
  output dp_stat_t          stat,
  output logic [TIME_W-1:0] now_word,
  output logic [TIME_W-1:0] alt_word,
  output logic [TIME_W-1:0] next_word
);

  localparam int HI = TIME_W - 1;
  localparam int D  = DIGIT_W;

  logic [TIME_W-1:0] now_sh_r;  // adjusted time
  logic [TIME_W-1:0] x_sh_r;    // first operand
  logic [TIME_W-1:0] y_sh_r;    // second operand
  logic [TIME_W-1:0] w_sh_r;    // collected result word
  logic [TIME_W-1:0] nx_sh_r;   // running minimum ticks to next due
  logic [TIME_W-1:0] off_r;     // sleep offset
  logic [4:0]        c_r;       // carries and borrows of the serial chains
  logic              ones_r;    // minimum is all ones so far

  logic [D-1:0] nd, xd, yd, od, qd;
  logic [D:0]   s0, s1, b0, b1, b2, b3, b4, f0, f1;
  logic [TIME_W-1:0] new_next;

  function automatic logic [D:0] dig_add(input logic [D-1:0] a, input logic [D-1:0] b,
                                         input logic ci);
    dig_add = {1'b0, a} + {1'b0, b} + {{D{1'b0}}, ci};
  endfunction

  // top bit of the result is the borrow
  function automatic logic [D:0] dig_sub(input logic [D-1:0] a, input logic [D-1:0] b,
                                         input logic bi);
    dig_sub = {1'b0, a} - {1'b0, b} - {{D{1'b0}}, bi};
  endfunction

  // one digit of every chain
  always_comb begin
    nd = now_sh_r[D-1:0];
    xd = x_sh_r[D-1:0];
    yd = y_sh_r[D-1:0];
    od = off_r[D-1:0];
    qd = nx_sh_r[D-1:0];
    // adjusted time and its backdated value
    s0 = dig_add(xd, od, c_r[0]);
    s1 = dig_add(s0[D-1:0], yd, c_r[1]);
    // since last run, due test, time left and the two minimum compares
    b0 = dig_sub(nd, xd, c_r[0]);
    b1 = dig_sub(b0[D-1:0], yd, c_r[1]);
    b2 = dig_sub(yd, b0[D-1:0], c_r[2]);
    b3 = dig_sub(b2[D-1:0], qd, c_r[3]);
    b4 = dig_sub(yd, qd, c_r[4]);
    // threshold compare and offset sum
    f0 = dig_sub(qd, xd, c_r[0]);
    f1 = dig_add(od, yd, c_r[1]);
  end

  // due channel restarts its full period, otherwise what is left of it
  always_comb begin
    new_next = nx_sh_r;
    if (!c_r[1]) begin
      if (c_r[4]) begin
        new_next = y_sh_r;
      end
    end else if (c_r[3]) begin
      new_next = w_sh_r;
    end
  end

  assign stat.chan_due   = ~c_r[1];
  assign stat.sleep_take = ctl.sleep_ok & ~c_r[0] & ~ones_r;

  // operand and result shift registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_LOAD_NOW: begin
        x_sh_r  <= cur_ms;
        y_sh_r  <= ~period_in;
        nx_sh_r <= '1;
        c_r     <= '0;
      end
      CMD_STEP_NOW: begin
        now_sh_r <= {s0[D-1:0], now_sh_r[HI:D]};
        w_sh_r   <= {s1[D-1:0], w_sh_r[HI:D]};
        x_sh_r   <= {x_sh_r[D-1:0], x_sh_r[HI:D]};
        y_sh_r   <= {y_sh_r[D-1:0], y_sh_r[HI:D]};
        c_r[0]   <= s0[D];
        c_r[1]   <= s1[D];
      end
      CMD_LOAD_CHAN: begin
        x_sh_r <= chan_last;
        y_sh_r <= chan_period;
        c_r    <= '0;
      end
      CMD_STEP_CHAN: begin
        now_sh_r <= {now_sh_r[D-1:0], now_sh_r[HI:D]};
        x_sh_r   <= {x_sh_r[D-1:0], x_sh_r[HI:D]};
        y_sh_r   <= {y_sh_r[D-1:0], y_sh_r[HI:D]};
        nx_sh_r  <= {nx_sh_r[D-1:0], nx_sh_r[HI:D]};
        w_sh_r   <= {b2[D-1:0], w_sh_r[HI:D]};
        c_r      <= {b4[D], b3[D], b2[D], b1[D], b0[D]};
      end
      CMD_END_CHAN: begin
        nx_sh_r <= new_next;
      end
      CMD_LOAD_FIN: begin
        x_sh_r <= min_sleep;
        y_sh_r <= granted;
        c_r    <= '0;
        ones_r <= 1'b1;
      end
      CMD_STEP_FIN: begin
        nx_sh_r <= {nx_sh_r[D-1:0], nx_sh_r[HI:D]};
        x_sh_r  <= {x_sh_r[D-1:0], x_sh_r[HI:D]};
        y_sh_r  <= {y_sh_r[D-1:0], y_sh_r[HI:D]};
        w_sh_r  <= {f1[D-1:0], w_sh_r[HI:D]};
        c_r[0]  <= f0[D];
        c_r[1]  <= f1[D];
        ones_r  <= ones_r & (&qd);
      end
      default: begin
      end
    endcase
  end

  // sleep offset rotates with each pass that reads it and takes the new sum on a sleep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= '0;
    end else begin
      case (ctl.cmd)
        CMD_STEP_NOW, CMD_STEP_FIN: begin
          off_r <= {off_r[D-1:0], off_r[HI:D]};
        end
        CMD_END_FIN: begin
          if (stat.sleep_take) begin
            off_r <= w_sh_r;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign now_word  = now_sh_r;
  assign alt_word  = w_sh_r;
  assign next_word = nx_sh_r;

endmodule

FILE: rtl/periodic_task_due_scheduler.sv
// Periodic task due scheduler, top level: stream ports, sequencer and configuration.
// Depends on pdts_pkg, pdts_chan_table and pdts_serial_path.
//
// Keeps up to MAX_TASKS periodic channels and answers one command word at a time:
// add a channel, set a channel's period, or poll at the current millisecond time.
// Time words go through an 8-bit digit-serial datapath in 32-bit passes.
// A poll runs one time pass, then a load, a pass and an update step per stored
// channel, then one pass for the sleep decision; an add runs a time pass and a
// table write (a full table answers without a pass), set period and unused codes
// go straight to the output, and any command may wait on out_tready.
// The next command word is taken once the current one has moved to the output
// register. Configuration writes are taken at any time with cfg_ready held high
// and must only be issued while no command is in flight. There is no clearing
// pass after reset; channel entries are valid once an add writes them.
module periodic_task_due_scheduler import pdts_pkg::*; #(
  parameter int MAX_TASKS = MAX_TASKS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // command words
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // current_ms, period_value, run_now, task_slot, granted_sleep, zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // opcode
  input  logic [OPCODE_W-1:0]   in_tuser,
  // result words
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // assigned_slot, due_mask, next_due_ticks, sleep_taken, time_slept, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [STATUS_W-1:0]   out_tuser,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TIME_W-1:0]     cfg_data
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  // sequencer states
  localparam int SW = 4;
  localparam logic [SW-1:0] S_IDLE    = 4'd0;
  localparam logic [SW-1:0] S_NOW_LD  = 4'd1;
  localparam logic [SW-1:0] S_NOW     = 4'd2;
  localparam logic [SW-1:0] S_ADD_WR  = 4'd3;
  localparam logic [SW-1:0] S_CH_LD   = 4'd4;
  localparam logic [SW-1:0] S_CH      = 4'd5;
  localparam logic [SW-1:0] S_CH_END  = 4'd6;
  localparam logic [SW-1:0] S_FIN_LD  = 4'd7;
  localparam logic [SW-1:0] S_FIN     = 4'd8;
  localparam logic [SW-1:0] S_FIN_END = 4'd9;
  localparam logic [SW-1:0] S_OUT     = 4'd10;

  logic [SW-1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     ch_r;
  logic [DIG_CNT_W-1:0] dig_r;
  logic                 out_tvalid_r;
  logic [MODE_W-1:0]    sleep_mode_r;
  logic [TIME_W-1:0]    min_sleep_r;

  // captured command fields
  logic [TIME_W-1:0] cur_r, per_r, gnt_r;
  logic              run_now_r;
  logic              op_add_r;
  logic              ran_r;

  // result being built
  logic [STATUS_W-1:0]   res_status_r;
  logic [ASSIGNED_W-1:0] res_slot_r;
  logic [DUE_W-1:0]      res_due_r;
  logic                  res_sleep_r;
  logic [TIME_W-1:0]     res_slept_r;
  logic                  res_poll_r;

  // output register
  logic [STATUS_W-1:0]   out_status_r;
  logic [ASSIGNED_W-1:0] out_slot_r;
  logic [DUE_W-1:0]      out_due_r;
  logic [TIME_W-1:0]     out_next_r;
  logic                  out_sleep_r;
  logic [TIME_W-1:0]     out_slept_r;

  // input fields
  logic [OPCODE_W-1:0]  in_op;
  logic [TIME_W-1:0]    in_cur, in_per, in_gnt;
  logic                 in_run;
  logic [SLOT_IN_W-1:0] in_slot;
  logic                 in_acc, out_free, dig_last, room, slot_ok;

  dp_ctl_t           dp_ctl;
  dp_stat_t          dp_stat;
  tbl_wr_t           tbl_wr;
  logic [IDX_W-1:0]  wr_idx;
  logic [TIME_W-1:0] wr_period, wr_last;
  logic [TIME_W-1:0] rd_period, rd_last;
  logic [TIME_W-1:0] now_word, alt_word, next_word;
  logic [CNT_W-1:0]  ch_inc;
  logic [IDX_W-1:0]  rd_idx;

  assign in_op   = in_tuser;
  assign in_cur  = in_tdata[IN_CUR_LSB +: TIME_W];
  assign in_per  = in_tdata[IN_PER_LSB +: TIME_W];
  assign in_run  = in_tdata[IN_RUN_LSB];
  assign in_slot = in_tdata[IN_SLOT_LSB +: SLOT_IN_W];
  assign in_gnt  = in_tdata[IN_GNT_LSB +: TIME_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;
  assign dig_last  = (dig_r == DIG_CNT_W'(NUM_DIG - 1));
  assign room      = (count_r < CNT_W'(MAX_TASKS));
  assign slot_ok   = (32'(in_slot) < MAX_TASKS);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_op)
            OP_ADD:  state_nxt = room ? S_NOW_LD : S_OUT;
            OP_POLL: state_nxt = S_NOW_LD;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_NOW_LD: state_nxt = S_NOW;
      S_NOW: begin
        if (dig_last) begin
          if (op_add_r) begin
            state_nxt = S_ADD_WR;
          end else if (count_r == '0) begin
            state_nxt = S_FIN_LD;
          end else begin
            state_nxt = S_CH_LD;
          end
        end
      end
      S_ADD_WR: state_nxt = S_OUT;
      S_CH_LD:  state_nxt = S_CH;
      S_CH: begin
        if (dig_last) begin
          state_nxt = S_CH_END;
        end
      end
      S_CH_END: state_nxt = (ch_r + CNT_W'(1) == count_r) ? S_FIN_LD : S_CH_LD;
      S_FIN_LD: state_nxt = S_FIN;
      S_FIN: begin
        if (dig_last) begin
          state_nxt = S_FIN_END;
        end
      end
      S_FIN_END: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath command per state
  always_comb begin
    dp_ctl.sleep_ok = (sleep_mode_r != '0) & ran_r;
    case (state_r)
      S_NOW_LD:  dp_ctl.cmd = CMD_LOAD_NOW;
      S_NOW:     dp_ctl.cmd = CMD_STEP_NOW;
      S_CH_LD:   dp_ctl.cmd = CMD_LOAD_CHAN;
      S_CH:      dp_ctl.cmd = CMD_STEP_CHAN;
      S_CH_END:  dp_ctl.cmd = CMD_END_CHAN;
      S_FIN_LD:  dp_ctl.cmd = CMD_LOAD_FIN;
      S_FIN:     dp_ctl.cmd = CMD_STEP_FIN;
      S_FIN_END: dp_ctl.cmd = CMD_END_FIN;
      default:   dp_ctl.cmd = CMD_IDLE;
    endcase
  end

  // table writes: set period, add, and marking a due channel as run
  always_comb begin
    tbl_wr    = '0;
    wr_idx    = count_r[IDX_W-1:0];
    wr_period = per_r;
    wr_last   = run_now_r ? alt_word : now_word;
    if (state_r == S_IDLE && in_acc && in_op == OP_SET_PERIOD && slot_ok) begin
      tbl_wr.we_period = 1'b1;
      wr_idx           = in_slot[IDX_W-1:0];
      wr_period        = in_per;
    end else if (state_r == S_ADD_WR) begin
      tbl_wr.we_period = 1'b1;
      tbl_wr.we_last   = 1'b1;
    end else if (state_r == S_CH_END && dp_stat.chan_due) begin
      tbl_wr.we_last = 1'b1;
      wr_idx         = ch_r[IDX_W-1:0];
      wr_last        = now_word;
    end
  end

  // table read address moves to the next channel at the end of each channel
  assign ch_inc = ch_r + CNT_W'(1);
  assign rd_idx = (state_r == S_CH_END) ? ch_inc[IDX_W-1:0] : ch_r[IDX_W-1:0];

  pdts_chan_table #(
    .MAX_TASKS (MAX_TASKS),
    .IDX_W     (IDX_W)
  ) u_table (
    .clk       (clk),
    .wr        (tbl_wr),
    .wr_idx    (wr_idx),
    .wr_period (wr_period),
    .wr_last   (wr_last),
    .rd_idx    (rd_idx),
    .rd_period (rd_period),
    .rd_last   (rd_last)
  );

  pdts_serial_path u_path (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (dp_ctl),
    .cur_ms      (cur_r),
    .period_in   (per_r),
    .granted     (gnt_r),
    .min_sleep   (min_sleep_r),
    .chan_period (rd_period),
    .chan_last   (rd_last),
    .stat        (dp_stat),
    .now_word    (now_word),
    .alt_word    (alt_word),
    .next_word   (next_word)
  );

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
      sleep_mode_r <= '0;
      min_sleep_r  <= MIN_SLEEP_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_ADD_WR) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (state_r == S_OUT && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLEEP_MODE: sleep_mode_r <= cfg_data[MODE_W-1:0];
          REG_MIN_SLEEP:  min_sleep_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // digit counter of the serial passes
  always_ff @(posedge clk) begin
    if (state_r == S_NOW || state_r == S_CH || state_r == S_FIN) begin
      dig_r <= dig_r + DIG_CNT_W'(1);
    end else begin
      dig_r <= '0;
    end
  end

  // command capture and result assembly
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_r        <= in_cur;
      per_r        <= in_per;
      gnt_r        <= in_gnt;
      run_now_r    <= in_run;
      op_add_r     <= (in_op == OP_ADD);
      ran_r        <= 1'b0;
      ch_r         <= '0;
      res_status_r <= ST_OK;
      res_slot_r   <= '0;
      res_due_r    <= '0;
      res_sleep_r  <= 1'b0;
      res_slept_r  <= '0;
      res_poll_r   <= (in_op == OP_POLL);
      case (in_op)
        OP_ADD: begin
          if (!room) begin
            res_status_r <= ST_FULL;
          end
        end
        OP_SET_PERIOD: begin
          if (!slot_ok) begin
            res_status_r <= ST_BAD_SLOT;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_ADD_WR) begin
      res_slot_r <= ASSIGNED_W'(count_r);
    end
    if (state_r == S_CH_END) begin
      if (dp_stat.chan_due) begin
        ran_r <= 1'b1;
        for (int i = 0; i < DUE_W; i++) begin
          if (32'(ch_r) == i) begin
            res_due_r[i] <= 1'b1;
          end
        end
      end
      ch_r <= ch_r + CNT_W'(1);
    end
    if (state_r == S_FIN_END) begin
      res_sleep_r <= dp_stat.sleep_take;
      res_slept_r <= dp_stat.sleep_take ? gnt_r : '0;
    end
    if (state_r == S_OUT && out_free) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_due_r    <= res_due_r;
      out_next_r   <= res_poll_r ? next_word : '0;
      out_sleep_r  <= res_sleep_r;
      out_slept_r  <= res_slept_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}}, out_slept_r, out_sleep_r,
                       out_next_r, out_due_r, out_slot_r};

  // table fill never passes its size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_TASKS))
    else $error("channel count beyond table size");

  // walk only visits stored channels
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CH || state_r == S_CH_END) |-> ch_r < count_r)
    else $error("channel walk past stored channels");

  // a sleep needs a channel still pending
  a_sleep_next: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_sleep_r) |-> out_next_r != '1)
    else $error("sleep taken with no channel pending");

  // time slept only reported with a sleep
  a_slept_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_sleep_r) |-> out_slept_r == '0)
    else $error("time slept without a sleep");

  // due channels only show on a successful result
  a_due_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && out_due_r != '0) |-> out_status_r == ST_OK)
    else $error("due mask on an error result");

endmodule

FILE: tb/tb.sv
// self-checking testbench for periodic_task_due_scheduler: directed and random command words
// depends on pdts_pkg and the rtl under rtl; carries its own prediction of the channel table
module tb;
  import pdts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = MAX_TASKS_DEFAULT;
  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int HALF_PHASE = 270;
  localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // result word layout
  localparam int OUT_DUE_LSB    = ASSIGNED_W;
  localparam int OUT_NEXT_LSB   = OUT_DUE_LSB + DUE_W;
  localparam int OUT_SLEPT_LSB  = OUT_NEXT_LSB + TIME_W;
  localparam int OUT_TSLEPT_LSB = OUT_SLEPT_LSB + 1;

  typedef struct packed {
    logic [OPCODE_W-1:0]  op;
    logic [TIME_W-1:0]    cur;
    logic [TIME_W-1:0]    per;
    logic                 run;
    logic [SLOT_IN_W-1:0] slot;
    logic [TIME_W-1:0]    gnt;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [ASSIGNED_W-1:0] slot;
    logic [DUE_W-1:0]      due;
    logic [TIME_W-1:0]     next_due;
    logic                  slept;
    logic [TIME_W-1:0]     tslept;
  } sched_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OPCODE_W-1:0]   in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [TIME_W-1:0]     cfg_data = '0;

  // predicted block state and register copies
  int                chan_count = 0;
  logic [TIME_W-1:0] chan_period [CHANNELS];
  logic [TIME_W-1:0] chan_last [CHANNELS];
  logic [TIME_W-1:0] wake_offset = '0;
  logic [MODE_W-1:0] cfg_mode = '0;
  logic [TIME_W-1:0] cfg_min_sleep = MIN_SLEEP_RESET;

  cmd_t       pending_cmds [$];
  sched_res_t expected_results [$];
  cmd_t       in_word;
  sched_res_t want;
  int         err_cnt = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  int         rx_hold_req = 0;
  int         rx_hold_ack = 0;
  int         rx_hold_left = 0;
  int         quiet_cycles = 0;
  logic [TIME_W-1:0] ms_clock = '0;

  periodic_task_due_scheduler #(.MAX_TASKS(CHANNELS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // pack one command word, first field lowest
  function automatic logic [IN_DATA_W-1:0] pack_cmd(cmd_t c);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[IN_CUR_LSB +: TIME_W]     = c.cur;
    w[IN_PER_LSB +: TIME_W]     = c.per;
    w[IN_RUN_LSB]               = c.run;
    w[IN_SLOT_LSB +: SLOT_IN_W] = c.slot;
    w[IN_GNT_LSB +: TIME_W]     = c.gnt;
    return w;
  endfunction

  // advance the predicted table by one command and return its result word
  function automatic sched_res_t predict_schedule(cmd_t c);
    sched_res_t r;
    logic [TIME_W-1:0] now, since, left;
    int ran;
    int i;
    r = '0;
    ran = 0;
    now = c.cur + wake_offset;
    case (c.op)
      OP_ADD: begin
        if (chan_count < CHANNELS) begin
          chan_period[chan_count] = c.per;
          // with run set, backdated by the period plus one so it is due at once unless that wraps
          chan_last[chan_count] = c.run ? now - (c.per + 32'd1) : now;
          r.slot = chan_count[ASSIGNED_W-1:0];
          chan_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_SET_PERIOD: begin
        if (c.slot < CHANNELS) chan_period[c.slot] = c.per;
        else r.status = ST_BAD_SLOT;
      end
      OP_POLL: begin
        r.next_due = '1;
        for (i = 0; i < chan_count; i++) begin
          since = now - chan_last[i];
          if (since >= chan_period[i]) begin
            ran++;
            r.due[i] = 1'b1;
            chan_last[i] = now;
            since = '0;
          end
          left = chan_period[i] - since;
          if (left < r.next_due) r.next_due = left;
        end
        // sleep only if enabled, something ran and the next due time is far enough
        if (cfg_mode != '0 && ran > 0 && r.next_due != '1 && r.next_due >= cfg_min_sleep) begin
          wake_offset = wake_offset + c.gnt;
          r.slept = 1'b1;
          r.tslept = c.gnt;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string what, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, exp_v, act_v);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SLEEP_MODE: cfg_mode = val[MODE_W-1:0];
      REG_MIN_SLEEP:  cfg_min_sleep = val;
      default: ;
    endcase
  endtask

  // block until every queued word is accepted and answered
  task automatic wait_drained();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_cmd(logic [OPCODE_W-1:0] op, logic [TIME_W-1:0] cur,
                           logic [TIME_W-1:0] per, logic run, logic [SLOT_IN_W-1:0] slot,
                           logic [TIME_W-1:0] gnt);
    cmd_t c;
    c.op = op; c.cur = cur; c.per = per; c.run = run; c.slot = slot; c.gnt = gnt;
    pending_cmds.push_back(c);
  endtask

  // mostly polls on a slowly advancing clock, with period rewrites, adds and noise
  task automatic queue_random(int n);
    cmd_t c;
    int pick;
    int p;
    repeat (n) begin
      pick = $urandom_range(99);
      c.cur = $urandom; c.per = $urandom; c.run = 1'($urandom);
      c.slot = SLOT_IN_W'($urandom);
      c.gnt = $urandom;
      if (pick < 62) begin
        c.op = OP_POLL;
        if ($urandom_range(99) < 3) ms_clock = $urandom;
        else ms_clock = ms_clock + $urandom_range(0, 24);
        c.cur = ms_clock;
        if ($urandom_range(99) < 80) c.gnt = $urandom_range(0, 15);
      end else if (pick < 82) begin
        c.op = OP_SET_PERIOD;
        if ($urandom_range(99) < 85) c.slot = SLOT_IN_W'($urandom_range(0, CHANNELS - 1));
        p = $urandom_range(99);
        if (p < 80) c.per = $urandom_range(1, 40);
        else if (p < 90) c.per = '0;
      end else if (pick < 94) begin
        c.op = OP_ADD;
        c.cur = ms_clock;
      end else begin
        c.op = OP_NOP;
      end
      pending_cmds.push_back(c);
    end
  endtask

  // driver: one command word per handshake, predicted when accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) expected_results.push_back(predict_schedule(in_word));
      if (!in_tvalid || in_tready) begin
        if (pending_cmds.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_word = pending_cmds.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= pack_cmd(in_word);
          in_tuser  <= in_word.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          err_cnt++;
          $display("%0t: result word with nothing expected, expected none, actual %h/%h",
                   $time, out_tuser, out_tdata);
        end else begin
          want = expected_results.pop_front();
          check_field("status", TIME_W'(want.status), TIME_W'(out_tuser));
          check_field("assigned_slot", TIME_W'(want.slot),
                      TIME_W'(out_tdata[0 +: ASSIGNED_W]));
          check_field("due_mask", TIME_W'(want.due),
                      TIME_W'(out_tdata[OUT_DUE_LSB +: DUE_W]));
          check_field("next_due_ticks", want.next_due, out_tdata[OUT_NEXT_LSB +: TIME_W]);
          check_field("sleep_taken", TIME_W'(want.slept),
                      TIME_W'(out_tdata[OUT_SLEPT_LSB]));
          check_field("time_slept", want.tslept, out_tdata[OUT_TSLEPT_LSB +: TIME_W]);
        end
      end
      // long hold-off on request, otherwise random back-pressure
      if (rx_hold_ack != rx_hold_req) begin
        rx_hold_ack = rx_hold_req;
        rx_hold_left = LONG_HOLD;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    tx_idle_pct = 32;
    rx_idle_pct = 65;
    write_reg(REG_SLEEP_MODE, 32'd1);
    write_reg(REG_MIN_SLEEP, MIN_SLEEP_RESET);
    queue_cmd(OP_POLL, 32'd0, 32'd0, 1'b0, 8'd0, 32'd5);             // empty table
    queue_cmd(OP_SET_PERIOD, '1, 32'd9, 1'b1, 8'd8, '1);              // bad index
    queue_cmd(OP_SET_PERIOD, 32'd0, 32'd9, 1'b0, 8'd255, 32'd0);      // bad index, top
    queue_cmd(OP_SET_PERIOD, 32'd0, 32'd123, 1'b0, 8'd7, 32'd0);      // slot not yet added
    queue_cmd(OP_NOP, '1, '1, 1'b1, '1, '1);
    queue_cmd(OP_ADD, 32'd0, 32'd50, 1'b0, 8'd0, 32'd0);
    queue_cmd(OP_POLL, 32'd0, 32'd0, 1'b0, 8'd0, 32'd1);
    queue_cmd(OP_POLL, 32'd60, 32'd0, 1'b0, 8'd0, 32'd7);             // due, sleeps
    queue_cmd(OP_ADD, 32'd100, '1, 1'b1, 8'd0, 32'd0);                // backdate wraps
    queue_cmd(OP_ADD, 32'hFFFF_FFF0, 32'd20, 1'b1, 8'd0, 32'd0);
    queue_cmd(OP_POLL, 32'hFFFF_FFF0, 32'd0, 1'b0, 8'd0, '1);         // offset wraps
    queue_cmd(OP_SET_PERIOD, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0);
    queue_cmd(OP_POLL, 32'd5, 32'd0, 1'b0, 8'd0, 32'd1);              // next below threshold
    queue_cmd(OP_ADD, 32'd6, 32'd0, 1'b1, 8'd0, 32'd0);
    queue_cmd(OP_ADD, 32'd7, 32'd3, 1'b0, 8'd0, 32'd0);
    queue_cmd(OP_ADD, 32'd8, 32'd1000, 1'b1, 8'd0, 32'd0);
    queue_cmd(OP_ADD, 32'd9, 32'd7, 1'b0, 8'd0, 32'd0);
    queue_cmd(OP_ADD, 32'd10, 32'd9, 1'b1, 8'd0, 32'd0);
    queue_cmd(OP_ADD, 32'd11, 32'd4, 1'b1, 8'd0, 32'd0);              // table full
    queue_cmd(OP_SET_PERIOD, 32'd0, '1, 1'b0, 8'd7, 32'd0);
    queue_cmd(OP_POLL, '1, 32'd0, 1'b0, 8'd0, 32'd2);
    queue_cmd(OP_POLL, 32'd12345, 32'd0, 1'b0, 8'd0, 32'd3);
    queue_cmd(OP_NOP, 32'd0, 32'd0, 1'b0, 8'd0, 32'd0);
    queue_cmd(OP_SET_PERIOD, 32'd0, 32'd0, 1'b0, 8'd3, 32'd0);
    queue_cmd(OP_POLL, 32'd12400, 32'd0, 1'b0, 8'd0, 32'd0);
    ms_clock = 32'd20000;

    // random phases, each split by a pause until all results are back
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      case (ph)
        0: begin
          tx_idle_pct = 32; rx_idle_pct = 65;
          write_reg(REG_SLEEP_MODE, TIME_W'({$urandom, 3'd7}));
          write_reg(REG_MIN_SLEEP, 32'd0);
          write_reg(REG_SPARE, $urandom);
        end
        1: begin
          tx_idle_pct = 65; rx_idle_pct = 32;
          write_reg(REG_SLEEP_MODE, TIME_W'({$urandom, 3'd0}));
          write_reg(REG_MIN_SLEEP, 32'd0);
        end
        default: begin
          tx_idle_pct = 0; rx_idle_pct = 0;
          write_reg(REG_SLEEP_MODE, $urandom_range(1, 6));
          write_reg(REG_MIN_SLEEP, '1);
        end
      endcase
      queue_random(HALF_PHASE);
      // hold the result side off while words keep coming
      if (ph == 0) rx_hold_req++;
      wait_drained();
      if (ph == 2) write_reg(REG_MIN_SLEEP, $urandom_range(1, 40));
      queue_random(HALF_PHASE);
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
